### rtl/core/iair_pkg.sv
package iair_pkg;

  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int READ_BITS = 32;
  localparam int POS_W     = $clog2(DEPTH);
  localparam int LEN_W     = $clog2(DEPTH + 1);
  localparam int ACT_W     = 3;

  localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESIZE = 3'd4;

  typedef enum logic [2:0] {
    TOK_NONE,
    TOK_READ,
    TOK_WRITE,
    TOK_INSERT,
    TOK_REMOVE
  } tok_op_t;

  // Command that walks down the row, one cell per cycle.
  typedef struct packed {
    logic                 valid;
    tok_op_t              op;
    logic [LEN_W-1:0]     idx;
    logic [LEN_W-1:0]     cnt;
    logic [WORD_BITS-1:0] data;
  } tok_t;

endpackage

### rtl/core/indexed_array_insert_remove.sv
// Takes one item at a time: each item walks the row of DEPTH cells one
// cell per cycle, and the next item is accepted only after the result
// of the last one has moved into the output register.
// Reset: synchronous, active low; clears every stored word and the length.
module indexed_array_insert_remove
  import iair_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [LEN_W-1:0]      in_index,
  input  logic signed [31:0]    in_value,
  input  logic [LEN_W-1:0]      in_new_length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_read_value,
  output logic                  out_ok,
  output logic [LEN_W-1:0]      out_length
);

  tok_t                 cell_tok  [DEPTH];
  logic [WORD_BITS-1:0] cell_word [DEPTH];

  tok_t             launch;
  logic             accept;
  logic             ok_now;
  tok_op_t          op_now;
  logic [LEN_W-1:0] len_now;

  logic             busy_r, busy_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             pend_ok_r, pend_ok_nxt;
  logic [LEN_W-1:0] pend_len_r, pend_len_nxt;
  logic             res_valid_r, res_valid_nxt;
  logic [READ_BITS-1:0] res_data_r, res_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [READ_BITS-1:0] out_data_r, out_data_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  tok_t             tail;
  logic             move_out;

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ok_now  = 1'b0;
    op_now  = TOK_NONE;
    len_now = count_r;
    unique case (in_action)
      ACT_READ: begin
        ok_now = (in_index < count_r);
        op_now = ok_now ? TOK_READ : TOK_NONE;
      end
      ACT_WRITE: begin
        ok_now = (in_index < count_r);
        op_now = ok_now ? TOK_WRITE : TOK_NONE;
      end
      ACT_INSERT: begin
        ok_now = (in_index <= count_r) && (count_r != LEN_W'(DEPTH));
        op_now = ok_now ? TOK_INSERT : TOK_NONE;
        if (ok_now) begin
          len_now = count_r + LEN_W'(1);
        end
      end
      ACT_REMOVE: begin
        ok_now = (in_index < count_r);
        op_now = ok_now ? TOK_REMOVE : TOK_NONE;
        if (ok_now) begin
          len_now = count_r - LEN_W'(1);
        end
      end
      ACT_RESIZE: begin
        ok_now = (in_new_length <= LEN_W'(DEPTH));
        if (ok_now) begin
          len_now = in_new_length;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    launch       = '0;
    launch.valid = accept;
    launch.op    = op_now;
    launch.idx   = in_index;
    launch.cnt   = count_r;
    launch.data  = (op_now == TOK_READ) ? '0 : WORD_BITS'(in_value);
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      tok_t                 tin;
      logic [WORD_BITS-1:0] nword;
      if (gi == 0) begin : g_head
        assign tin = launch;
      end else begin : g_body
        assign tin = cell_tok[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign nword = '0;
      end else begin : g_mid
        assign nword = cell_word[gi+1];
      end
      iair_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos       (POS_W'(gi)),
        .tok_in    (tin),
        .next_word (nword),
        .tok_out   (cell_tok[gi]),
        .word      (cell_word[gi])
      );
    end
  endgenerate

  assign tail     = cell_tok[DEPTH-1];
  assign move_out = res_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    pend_ok_nxt   = pend_ok_r;
    pend_len_nxt  = pend_len_r;
    res_valid_nxt = res_valid_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;
    out_len_nxt   = out_len_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (move_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data_r;
      out_ok_nxt    = pend_ok_r;
      out_len_nxt   = pend_len_r;
      res_valid_nxt = 1'b0;
      busy_nxt      = 1'b0;
    end
    // capture the item's result when its command leaves the last cell
    if (tail.valid) begin
      res_valid_nxt = 1'b1;
      res_data_nxt  = (tail.op == TOK_READ) ? READ_BITS'(tail.data) : '0;
    end
    if (accept) begin
      busy_nxt     = 1'b1;
      count_nxt    = len_now;
      pend_ok_nxt  = ok_now;
      pend_len_nxt = len_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_ok_r  <= pend_ok_nxt;
    pend_len_r <= pend_len_nxt;
    res_data_r <= res_data_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;
  assign out_ok         = out_ok_r;
  assign out_length     = out_len_r;

endmodule

### rtl/core/iair_cell.sv
module iair_cell
  import iair_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [POS_W-1:0]     pos,
  input  tok_t                 tok_in,
  input  logic [WORD_BITS-1:0] next_word,
  output tok_t                 tok_out,
  output logic [WORD_BITS-1:0] word
);

  logic [WORD_BITS-1:0] word_r, word_nxt;
  tok_t                 tok_r, tok_nxt;
  logic [LEN_W-1:0]     here;
  logic                 at_idx;
  logic                 from_idx;

  assign here     = LEN_W'(pos);
  assign at_idx   = (here == tok_in.idx);
  assign from_idx = (here >= tok_in.idx);

  always_comb begin
    word_nxt = word_r;
    tok_nxt  = tok_in;
    if (tok_in.valid) begin
      case (tok_in.op)
        TOK_READ: begin
          if (at_idx) begin
            tok_nxt.data = word_r;
          end
        end
        TOK_WRITE: begin
          if (at_idx) begin
            word_nxt = tok_in.data;
          end
        end
        TOK_INSERT: begin
          // swap: keep the carried word, pass the old one up
          if (from_idx && (here <= tok_in.cnt)) begin
            word_nxt     = tok_in.data;
            tok_nxt.data = word_r;
          end
        end
        TOK_REMOVE: begin
          // right neighbor is not yet touched by this item
          if (from_idx && ((here + LEN_W'(1)) < tok_in.cnt)) begin
            word_nxt = next_word;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      tok_r  <= '0;
    end else begin
      word_r <= word_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign word    = word_r;

endmodule
